[hw/rtl/nrexp_pkg.sv]
// Package holding the shared types and constants of the NACK request expander.
package nrexp_pkg;

  localparam int unsigned SeqW      = 16;
  localparam int unsigned MaskBits  = 16;
  localparam int unsigned CycleW    = 32;
  localparam int unsigned ExtW      = CycleW + SeqW;
  localparam int unsigned BitIdxW   = $clog2(MaskBits);
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [SeqW-1:0] HalfRange = {1'b1, {(SeqW-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_NEWER    = 2'd1,
    ST_PRE_WRAP = 2'd2
  } status_e;

  // One classified feedback word as it sits in the queue between front and back.
  typedef struct packed {
    logic [SeqW-1:0]     packet_id;
    logic [MaskBits-1:0] lost_mask;
    logic [SeqW-1:0]     highest_seq;
    logic [CycleW-1:0]   highest_cycle;
    logic [CycleW-1:0]   prev_cycle;
    logic                cycle_zero;
  } word_t;

endpackage

[hw/rtl/nrexp_intf.sv]
// Handshake interfaces for the feedback word beats and the result beats.
interface nrexp_in_if;
  logic                          valid;
  logic                          ready;
  logic [nrexp_pkg::SeqW-1:0]     packet_id;
  logic [nrexp_pkg::MaskBits-1:0] lost_mask;
  logic [nrexp_pkg::SeqW-1:0]     highest_seq;
  logic [nrexp_pkg::CycleW-1:0]   highest_cycle;

  modport source (output valid, packet_id, lost_mask, highest_seq, highest_cycle,
                  input ready);
  modport sink (input valid, packet_id, lost_mask, highest_seq, highest_cycle,
                output ready);
endinterface

interface nrexp_out_if;
  logic                      valid;
  logic                      ready;
  logic [nrexp_pkg::SeqW-1:0] seq;
  logic [nrexp_pkg::ExtW-1:0] extended_seq;
  logic [1:0]                 status;
  logic                       last;

  modport source (output valid, seq, extended_seq, status, last, input ready);
  modport sink (input valid, seq, extended_seq, status, last, output ready);
endinterface

[hw/rtl/nrexp_front.sv]
// Front end: takes feedback word beats and precomputes the wrap count information.
module nrexp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  nrexp_in_if.sink         in_i,
  output logic             word_valid_o,
  output nrexp_pkg::word_t word_o,
  input  logic             word_ready_i
);

  logic             valid_q, valid_d;
  nrexp_pkg::word_t word_q, word_d;
  logic             take;

  assign in_i.ready = !valid_q || word_ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (take) begin
      valid_d               = 1'b1;
      word_d.packet_id      = in_i.packet_id;
      word_d.lost_mask      = in_i.lost_mask;
      word_d.highest_seq    = in_i.highest_seq;
      word_d.highest_cycle  = in_i.highest_cycle;
      word_d.prev_cycle     = in_i.highest_cycle - {{(nrexp_pkg::CycleW-1){1'b0}}, 1'b1};
      word_d.cycle_zero     = (in_i.highest_cycle == '0);
    end else if (word_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

[hw/rtl/nrexp_fifo.sv]
// Short queue of classified words between the front end and the back end.
module nrexp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  nrexp_pkg::word_t push_word_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output nrexp_pkg::word_t pop_word_o
);

  nrexp_pkg::word_t                   mem_q [nrexp_pkg::FifoDepth];
  logic [nrexp_pkg::FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [nrexp_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic                               push, pop;

  assign push_ready_o = (cnt_q != nrexp_pkg::FifoCntW'(nrexp_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_word_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == nrexp_pkg::FifoPtrW'(nrexp_pkg::FifoDepth - 1)) ? '0
               : wr_ptr_q + nrexp_pkg::FifoPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == nrexp_pkg::FifoPtrW'(nrexp_pkg::FifoDepth - 1)) ? '0
               : rd_ptr_q + nrexp_pkg::FifoPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + nrexp_pkg::FifoCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - nrexp_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  // The fill count never goes beyond the queue depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= nrexp_pkg::FifoCntW'(nrexp_pkg::FifoDepth))
    else $error("queue fill count beyond depth");

  // A pop without a push empties one slot.
  a_cnt_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - nrexp_pkg::FifoCntW'(1)))
    else $error("queue count did not drop after a pop");

  // An empty queue has its read and write pointers together.
  a_ptr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers apart while empty");

endmodule

[hw/rtl/nrexp_back.sv]
// Back end: walks the lost mask of one word and emits one resolved result per cycle unless the output stalls.
module nrexp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_valid_i,
  output logic             word_ready_o,
  input  nrexp_pkg::word_t word_i,
  nrexp_out_if.source      out_o
);

  logic                              busy_q, busy_d;
  logic                              first_q, first_d;
  nrexp_pkg::word_t                  cur_q, cur_d;
  logic [nrexp_pkg::MaskBits-1:0]    rem_q, rem_d;

  logic                              out_valid_q, out_valid_d;
  logic [nrexp_pkg::SeqW-1:0]        seq_q, seq_d;
  logic [nrexp_pkg::ExtW-1:0]        ext_q, ext_d;
  nrexp_pkg::status_e                status_q, status_d;
  logic                              last_q, last_d;

  logic                              advance, load;
  logic [nrexp_pkg::BitIdxW-1:0]     low_idx;
  logic [nrexp_pkg::MaskBits-1:0]    rem_next;
  logic [nrexp_pkg::SeqW-1:0]        s, diff;
  logic                              is_last, newer, is_equal, prev_wrap;
  logic [nrexp_pkg::CycleW-1:0]      cycle;
  nrexp_pkg::status_e                status;

  // Lowest set bit of the remaining mask.
  always_comb begin
    low_idx = '0;
    for (int i = nrexp_pkg::MaskBits - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        low_idx = nrexp_pkg::BitIdxW'(i);
      end
    end
  end

  always_comb begin
    if (first_q) begin
      s        = cur_q.packet_id;
      rem_next = rem_q;
    end else begin
      s        = cur_q.packet_id + nrexp_pkg::SeqW'(low_idx) + nrexp_pkg::SeqW'(1);
      rem_next = rem_q & (rem_q - nrexp_pkg::MaskBits'(1));
    end
    is_last = (rem_next == '0);
  end

  // Resolve the number against the highest sent number and its wrap count.
  always_comb begin
    diff      = s - cur_q.highest_seq;
    is_equal  = (diff == '0);
    newer     = (diff == nrexp_pkg::HalfRange) ? (s > cur_q.highest_seq)
              : (!is_equal && (diff < nrexp_pkg::HalfRange));
    prev_wrap = !is_equal && !newer && (s > cur_q.highest_seq);
    cycle     = prev_wrap ? cur_q.prev_cycle : cur_q.highest_cycle;
    if (newer) begin
      status = nrexp_pkg::ST_NEWER;
    end else if (prev_wrap && cur_q.cycle_zero) begin
      status = nrexp_pkg::ST_PRE_WRAP;
    end else begin
      status = nrexp_pkg::ST_VALID;
    end
  end

  assign advance      = busy_q && (!out_valid_q || out_o.ready);
  assign word_ready_o = !busy_q || (advance && is_last);
  assign load         = word_valid_i && word_ready_o;

  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    cur_d   = cur_q;
    rem_d   = rem_q;
    if (advance) begin
      first_d = 1'b0;
      rem_d   = rem_next;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cur_d   = word_i;
      rem_d   = word_i.lost_mask;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    seq_d       = seq_q;
    ext_d       = ext_q;
    status_d    = status_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      seq_d       = s;
      ext_d       = (status == nrexp_pkg::ST_VALID) ? {cycle, s} : '0;
      status_d    = status;
      last_d      = is_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    rem_q    <= rem_d;
    seq_q    <= seq_d;
    ext_q    <= ext_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.seq          = seq_q;
  assign out_o.extended_seq = ext_q;
  assign out_o.status       = status_q;
  assign out_o.last         = last_q;

  // A flagged result never carries an extended number.
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != nrexp_pkg::ST_VALID)) |-> (ext_q == '0))
    else $error("flagged result with nonzero extended number");

  // The back end only goes idle right after emitting the final result of a word.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(advance && is_last))
    else $error("back end went idle without a final result");

  // A valid result's extended number ends in its sequence number.
  a_ext_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == nrexp_pkg::ST_VALID)) |->
      (ext_q[nrexp_pkg::SeqW-1:0] == seq_q))
    else $error("extended number does not match sequence number");

endmodule

[hw/rtl/nack_request_expand_unwrap.sv]
// Top level of the NACK request expander: front end, word queue and back end.
//
// This block expands one generic NACK feedback word (a packet id and a 16-bit
// lost-packet mask, together with the sender's highest sent sequence number and
// its wrap count) into one result beat per requested sequence number: first the
// packet id, then packet id plus k plus one for every set mask bit k, in
// ascending order of k. Each result carries the 16-bit number, its 48-bit
// extended form (wrap count above the number), a status and a last flag that
// marks the final beat of the word. A number newer than the highest sent one is
// given status 1, and one that falls in the wrap before the first gives status
// 2; both have a zero extended number. A word yields between 1 and 17 result
// beats; the back end emits one result per cycle while the result channel is
// not stalled. The front end registers each incoming beat and precomputes the
// previous wrap count, and a two-entry queue lets it take further words while
// the back end is still busy or the result channel is stalled. With a ready
// sink the first result of a word passes the front-end register, the queue and
// the back end's word and result registers, and consecutive words follow one
// another on the result channel without gaps. The block keeps no state between
// words; reset only clears the handshake state.
module nack_request_expand_unwrap (
  input  logic        clk_i,
  input  logic        rst_ni,
  nrexp_in_if.sink    in_i,
  nrexp_out_if.source out_o
);

  logic             front_valid, front_ready;
  nrexp_pkg::word_t front_word;
  logic             queue_valid, queue_ready;
  nrexp_pkg::word_t queue_word;

  nrexp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .word_valid_o (front_valid),
    .word_o       (front_word),
    .word_ready_i (front_ready)
  );

  nrexp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_word_i  (front_word),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_word_o   (queue_word)
  );

  nrexp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (queue_valid),
    .word_ready_o (queue_ready),
    .word_i       (queue_word),
    .out_o        (out_o)
  );

endmodule

[verif/nack_request_expand_unwrap_test.sv]
// Self-checking testbench for the NACK request expander, with its own result predictor.
`timescale 1ns / 1ps

module nack_request_expand_unwrap_test;

  // This limit leaves a wide margin over the slowest correct run.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomWords = 280;
  localparam int unsigned HoldOffLen  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned IdlePercent = 28;

  // One beat on the result channel, as the predictor expects it.
  typedef struct packed {
    logic [nrexp_pkg::SeqW-1:0] seq;
    logic [nrexp_pkg::ExtW-1:0] ext_seq;
    nrexp_pkg::status_e         status;
    logic                       last;
  } result_beat_t;

  // One feedback word to send. Where has_result is set, the word has an empty
  // mask and its single result beat is written out in the row itself.
  typedef struct packed {
    logic [nrexp_pkg::SeqW-1:0]     packet_id;
    logic [nrexp_pkg::MaskBits-1:0] lost_mask;
    logic [nrexp_pkg::SeqW-1:0]     highest_seq;
    logic [nrexp_pkg::CycleW-1:0]   highest_cycle;
    logic                           has_result;
    logic [nrexp_pkg::SeqW-1:0]     seq;
    logic [nrexp_pkg::ExtW-1:0]     ext_seq;
    nrexp_pkg::status_e             status;
  } feedback_row_t;

  localparam int unsigned NumDirected = 19;

  logic clk_i;
  logic rst_ni;

  nrexp_in_if  word_if ();
  nrexp_out_if result_if ();

  nack_request_expand_unwrap i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_if),
    .out_o  (result_if)
  );

  result_beat_t  expected_beats[$];
  feedback_row_t directed_rows[NumDirected];
  int unsigned   error_count;
  int unsigned   cycle_count;
  // Set by the stimulus to ask both sides to stop idling for a while.
  logic          steady_flow;
  // Set by the stimulus once; the receiver then stalls for a long stretch.
  logic          hold_off_req;
  logic          hold_off_done;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Works out the unwrapped form of one requested sequence number. A number
  // counts as newer than the highest sent one when the 16-bit distance to it
  // lies between one and just below half the range; at exactly one half the
  // larger raw value is taken as the newer one.
  function automatic result_beat_t unwrap_seq(logic [nrexp_pkg::SeqW-1:0] seq,
                                              logic [nrexp_pkg::SeqW-1:0] highest_seq,
                                              logic [nrexp_pkg::CycleW-1:0] highest_cycle);
    result_beat_t               beat;
    logic [nrexp_pkg::SeqW-1:0] gap;
    logic                       newer;
    gap   = seq - highest_seq;
    newer = (gap == nrexp_pkg::HalfRange) ? (seq > highest_seq)
          : (gap != '0 && gap < nrexp_pkg::HalfRange);
    beat.seq     = seq;
    beat.last    = 1'b0;
    beat.status  = nrexp_pkg::ST_VALID;
    beat.ext_seq = {highest_cycle, seq};
    if (seq == highest_seq) begin
      // Same number as the highest: same wrap.
    end else if (newer) begin
      beat.status  = nrexp_pkg::ST_NEWER;
      beat.ext_seq = '0;
    end else if (seq > highest_seq) begin
      // Numerically above but older: it sits in the previous wrap, which does
      // not exist while the wrap count is still zero.
      if (highest_cycle == '0) begin
        beat.status  = nrexp_pkg::ST_PRE_WRAP;
        beat.ext_seq = '0;
      end else begin
        beat.ext_seq = {highest_cycle - 32'd1, seq};
      end
    end
    return beat;
  endfunction

  // Queues the result beats of one feedback word: the packet id first, then
  // one beat per set mask bit in ascending order, the final one marked last.
  function automatic void expand_word(feedback_row_t row);
    result_beat_t               beat;
    int unsigned                total;
    int unsigned                count;
    logic [nrexp_pkg::SeqW-1:0] seq;
    total = 1 + $countones(row.lost_mask);
    count = 1;
    beat = unwrap_seq(row.packet_id, row.highest_seq, row.highest_cycle);
    beat.last = (count == total);
    expected_beats = {expected_beats, beat};
    for (int k = 0; k < nrexp_pkg::MaskBits; k++) begin
      if (row.lost_mask[k]) begin
        count = count + 1;
        seq   = row.packet_id + nrexp_pkg::SeqW'(k + 1);
        beat  = unwrap_seq(seq, row.highest_seq, row.highest_cycle);
        beat.last = (count == total);
        expected_beats = {expected_beats, beat};
      end
    end
  endfunction

  // Builds a random feedback word. Half the words keep the packet id close to the
  // highest sent number, where the newer, older and previous-wrap decisions
  // all meet; the rest sit half a range away or are fully random.
  function automatic feedback_row_t random_row();
    feedback_row_t row;
    row = '0;
    row.highest_seq = nrexp_pkg::SeqW'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: row.packet_id = row.highest_seq
                                     + nrexp_pkg::SeqW'($urandom_range(0, 63)) - 16'd40;
      5, 6:          row.packet_id = row.highest_seq + nrexp_pkg::HalfRange
                                     + nrexp_pkg::SeqW'($urandom_range(0, 31)) - 16'd24;
      default:       row.packet_id = nrexp_pkg::SeqW'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       row.lost_mask = '0;
      1:       row.lost_mask = '1;
      2:       row.lost_mask = nrexp_pkg::MaskBits'(1)
                               << $urandom_range(0, nrexp_pkg::MaskBits - 1);
      default: row.lost_mask = nrexp_pkg::MaskBits'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       row.highest_cycle = '0;
      1:       row.highest_cycle = 32'd1;
      2:       row.highest_cycle = '1;
      default: row.highest_cycle = $urandom;
    endcase
    return row;
  endfunction

  // Offers one feedback word, entered at a falling edge and left at the
  // falling edge after the beat was taken. A random gap may come first; valid
  // is only lowered inside such a gap, so back-to-back beats keep it high.
  task automatic offer_word(feedback_row_t row);
    result_beat_t beat;
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < IdlePercent) begin
        word_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    word_if.valid         <= 1'b1;
    word_if.packet_id     <= row.packet_id;
    word_if.lost_mask     <= row.lost_mask;
    word_if.highest_seq   <= row.highest_seq;
    word_if.highest_cycle <= row.highest_cycle;
    do begin
      @(posedge clk_i);
    end while (!word_if.ready);
    if (row.has_result) begin
      beat.seq     = row.seq;
      beat.ext_seq = row.ext_seq;
      beat.status  = row.status;
      beat.last    = 1'b1;
      expected_beats = {expected_beats, beat};
    end else begin
      expand_word(row);
    end
    @(negedge clk_i);
  endtask

  // Stimulus: reset, the directed table, then the random words.
  initial begin
    rst_ni                = 1'b0;
    steady_flow           = 1'b0;
    hold_off_req          = 1'b0;
    word_if.valid         = 1'b0;
    word_if.packet_id     = '0;
    word_if.lost_mask     = '0;
    word_if.highest_seq   = '0;
    word_if.highest_cycle = '0;

    // Rows with an empty mask carry their one result beat, which can be read
    // straight off the rules; the others go through the predictor.
    directed_rows = '{
      // Everything zero: equal to the highest, wrap count zero.
      '{16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
        1'b1, 16'h0000, 48'h0, nrexp_pkg::ST_VALID},
      // Packet id, highest sent number and wrap count at their maximum.
      '{16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF,
        1'b1, 16'hFFFF, 48'hFFFF_FFFF_FFFF, nrexp_pkg::ST_VALID},
      // Just above the highest sent number.
      '{16'h0001, 16'h0000, 16'h0000, 32'h0000_0005,
        1'b1, 16'h0001, 48'h0, nrexp_pkg::ST_NEWER},
      // Largest distance below half the range, which counts as newer.
      '{16'h7FFF, 16'h0000, 16'h0000, 32'h0000_0001,
        1'b1, 16'h7FFF, 48'h0, nrexp_pkg::ST_NEWER},
      // Half a range apart, larger raw value: newer.
      '{16'h8000, 16'h0000, 16'h0000, 32'h0000_0005,
        1'b1, 16'h8000, 48'h0, nrexp_pkg::ST_NEWER},
      '{16'hFFFF, 16'h0000, 16'h7FFF, 32'h0000_0000,
        1'b1, 16'hFFFF, 48'h0, nrexp_pkg::ST_NEWER},
      // Half a range apart, smaller raw value: older, same wrap.
      '{16'h0000, 16'h0000, 16'h8000, 32'h0000_0007,
        1'b1, 16'h0000, 48'h0000_0007_0000, nrexp_pkg::ST_VALID},
      // Previous wrap while the wrap count is zero.
      '{16'h8001, 16'h0000, 16'h0000, 32'h0000_0000,
        1'b1, 16'h8001, 48'h0, nrexp_pkg::ST_PRE_WRAP},
      '{16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0000,
        1'b1, 16'hFFFF, 48'h0, nrexp_pkg::ST_PRE_WRAP},
      // Previous wrap with a nonzero wrap count.
      '{16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0001,
        1'b1, 16'hFFFF, 48'h0000_0000_FFFF, nrexp_pkg::ST_VALID},
      '{16'h8001, 16'h0000, 16'h0000, 32'h8000_0000,
        1'b1, 16'h8001, 48'h7FFF_FFFF_8001, nrexp_pkg::ST_VALID},
      // Numerically below the highest, same wrap.
      '{16'h0010, 16'h0000, 16'h0020, 32'h0000_0003,
        1'b1, 16'h0010, 48'h0000_0003_0010, nrexp_pkg::ST_VALID},
      // Full mask running across the sequence number wrap.
      '{16'hFFF8, 16'hFFFF, 16'h0002, 32'h0000_0009,
        1'b0, 16'h0, 48'h0, nrexp_pkg::ST_VALID},
      // Only the top mask bit, from the top packet id.
      '{16'hFFFF, 16'h8000, 16'hFFFF, 32'h0000_0000,
        1'b0, 16'h0, 48'h0, nrexp_pkg::ST_VALID},
      // Only the bottom mask bit.
      '{16'h0000, 16'h0001, 16'h0000, 32'h0000_0001,
        1'b0, 16'h0, 48'h0, nrexp_pkg::ST_VALID},
      '{16'h1234, 16'hAAAA, 16'h1240, 32'hDEAD_BEEF,
        1'b0, 16'h0, 48'h0, nrexp_pkg::ST_VALID},
      // Full mask across the half-range point: newer turns into previous wrap.
      '{16'h7FF8, 16'hFFFF, 16'h0000, 32'h0000_0000,
        1'b0, 16'h0, 48'h0, nrexp_pkg::ST_VALID},
      '{16'h7FF8, 16'h5555, 16'hFFF8, 32'hFFFF_FFFF,
        1'b0, 16'h0, 48'h0, nrexp_pkg::ST_VALID},
      '{16'hFFF0, 16'hFFFF, 16'hFFFF, 32'h0000_0000,
        1'b0, 16'h0, 48'h0, nrexp_pkg::ST_VALID}
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      offer_word(directed_rows[i]);
    end

    for (int i = 0; i < RandomWords; i++) begin
      // A long receiver stall early on, while words keep coming.
      if (i == 40) begin
        hold_off_req = 1'b1;
      end
      // A stretch in which neither side idles, so beats run back to back.
      steady_flow = (i >= 150 && i < 200);
      offer_word(random_row());
    end
    word_if.valid <= 1'b0;
    steady_flow = 1'b0;

    while (expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS nack_request_expand_unwrap");
    end else begin
      $display("FAIL nack_request_expand_unwrap");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off when asked for, and no
  // stalls during the steady stretch.
  initial begin
    hold_off_done   = 1'b0;
    result_if.ready = 1'b0;
    while (!rst_ni) begin
      @(negedge clk_i);
    end
    forever begin
      if (hold_off_req && !hold_off_done) begin
        result_if.ready <= 1'b0;
        repeat (HoldOffLen) @(negedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        result_if.ready <= steady_flow || ($urandom_range(0, 99) >= IdlePercent);
        @(negedge clk_i);
      end
    end
  end

  // Each accepted result beat is compared with the oldest expected one.
  always @(posedge clk_i) begin
    result_beat_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_beats.size() == 0) begin
        $error("Unexpected result beat: seq %0h", result_if.seq);
        error_count = error_count + 1;
      end else begin
        want = expected_beats.pop_front();
        if (result_if.seq !== want.seq) begin
          $error("seq: expected %0h, got %0h", want.seq, result_if.seq);
          error_count = error_count + 1;
        end
        if (result_if.extended_seq !== want.ext_seq) begin
          $error("extended_seq: expected %0h, got %0h", want.ext_seq, result_if.extended_seq);
          error_count = error_count + 1;
        end
        if (result_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_if.status);
          error_count = error_count + 1;
        end
        if (result_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_if.last);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    error_count = 0;
    cycle_count = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL nack_request_expand_unwrap");
      $finish;
    end
  end

endmodule

[filelist.f]
hw/rtl/nrexp_pkg.sv
hw/rtl/nrexp_intf.sv
hw/rtl/nrexp_front.sv
hw/rtl/nrexp_fifo.sv
hw/rtl/nrexp_back.sv
hw/rtl/nack_request_expand_unwrap.sv
verif/nack_request_expand_unwrap_test.sv
